/* src/tpl_pkg.sv */
// Shared widths, constants and request codes of the tetrahedral point locator.
// No dependencies; used by tpl_div and tetra_point_locator_unit.
`timescale 1ns / 1ps
`default_nettype none

package tpl_pkg;

	localparam int COORD_W   = 16;            // Q4.12 coordinate
	localparam int DIFF_W    = 17;            // difference of two coordinates
	localparam int CROSS_W   = 35;            // cross product component
	localparam int ACC_W     = 52;            // determinant and cofactor sums
	localparam int QW        = 24;            // quotient bits, Q8.16
	localparam int INT_STEPS = 8;             // integer quotient bits
	localparam int DVW       = ACC_W + INT_STEPS;
	localparam int WW        = 24;            // weight width
	localparam int ERR_W     = 50;            // sum of four squared distances

	localparam logic signed [WW-1:0] W_MAX   = 24'sh7FFFFF;
	localparam logic signed [WW-1:0] W_MIN   = 24'sh800000;
	localparam logic        [QW:0]   MAG_SAT = 25'h1000000;
	localparam logic        [QW:0]   MAG_NEG = 25'h0800000;
	localparam logic        [QW:0]   MAG_POS = 25'h07FFFFF;

	typedef enum logic [1:0] {
		REQ_VERT = 2'd0,
		REQ_TET  = 2'd1,
		REQ_LOC  = 2'd2
	} req_t;

	// cyclic successors of an axis or edge index 0..2
	function automatic logic [1:0] nx1(input logic [1:0] k);
		case (k)
			2'd0:    nx1 = 2'd1;
			2'd1:    nx1 = 2'd2;
			default: nx1 = 2'd0;
		endcase
	endfunction

	function automatic logic [1:0] nx2(input logic [1:0] k);
		case (k)
			2'd0:    nx2 = 2'd2;
			2'd1:    nx2 = 2'd0;
			default: nx2 = 2'd1;
		endcase
	endfunction

endpackage

`default_nettype wire

/* src/tetra_point_locator_unit.sv */
// Tetrahedral point locator: vertex and element memories, scan sequencer, output register.
// Depends on tpl_pkg and tpl_div.
//
// Usage. One input stream (s_*): tuser carries the request kind, tdata the slot,
// the point or vertex coordinates and the four corner indices. A vertex or
// tetrahedron write is taken and gives no output word. A locate request scans
// elements 0 .. min(elem_count, MAX_ELEMS)-1 and yields one word on the output
// stream (m_*), tuser holding found.
// Per element: one element read, four vertex reads, the nine cross product
// components on two multipliers, then the twelve dot product terms of four dot
// products on a third, then the three 24-step dividers run side by side, followed
// by the saturated weights and the summed squared distances of the four weights.
// A degenerate element (zero determinant) is dropped before the dividers start.
// With n = 0 the word is given without a scan. The next request can be taken
// once the word is loaded.
// The input is not taken while a scan runs. A finished result sits in the
// output register; the next request is taken while it waits, and a new scan
// holds at its end until the receiver has taken the previous word.
// Reset clears elem_count and the handshake state; table contents are
// undefined until written. elem_count is written through cfg_we / cfg_wdata.
`timescale 1ns / 1ps
`default_nettype none

module tetra_point_locator_unit #(
	parameter int MAX_VERTS = 256,
	parameter int MAX_ELEMS = 1024
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [10:0]  cfg_wdata,
	input  logic         s_tvalid,
	output logic         s_tready,
	// slot[9:0] coord_x[25:10] coord_y[41:26] coord_z[57:42]
	// vert_a[65:58] vert_b[73:66] vert_c[81:74] vert_d[89:82], zero fill
	input  logic [95:0]  s_tdata,
	// req_type[1:0]
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// elem_index[9:0] corner_a[17:10] corner_b[25:18] corner_c[33:26]
	// corner_d[41:34] weight_a[65:42] weight_b[89:66] weight_c[113:90]
	// weight_d[137:114], zero fill
	output logic [143:0] m_tdata,
	// found[0]
	output logic [0:0]   m_tuser
);

	localparam int VAW = $clog2(MAX_VERTS);
	localparam int EAW = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
	localparam int EIW = $clog2(MAX_ELEMS + 1);
	localparam int DW  = tpl_pkg::DIFF_W;
	localparam int CRW = tpl_pkg::CROSS_W;
	localparam int AW  = tpl_pkg::ACC_W;
	localparam int WW  = tpl_pkg::WW;
	localparam int EW  = tpl_pkg::ERR_W;

	typedef enum logic [11:0] {
		ST_IDLE   = 12'b000000000001,
		ST_ERD    = 12'b000000000010,
		ST_VRD    = 12'b000000000100,
		ST_CROSS  = 12'b000000001000,
		ST_DOT    = 12'b000000010000,
		ST_DSTART = 12'b000000100000,
		ST_DWAIT  = 12'b000001000000,
		ST_WGT    = 12'b000010000000,
		ST_WD     = 12'b000100000000,
		ST_ERR    = 12'b001000000000,
		ST_UPD    = 12'b010000000000,
		ST_DONE   = 12'b100000000000
	} state_t;

	state_t state_q;

	// input word fields
	tpl_pkg::req_t req;
	logic [9:0]  slot;
	logic [15:0] in_c [3];
	logic        in_acc;

	assign req     = tpl_pkg::req_t'(s_tuser);
	assign slot    = s_tdata[9:0];
	assign in_c[0] = s_tdata[25:10];
	assign in_c[1] = s_tdata[41:26];
	assign in_c[2] = s_tdata[57:42];
	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;

	// control registers
	logic [10:0]    elem_count_q;
	logic [EIW-1:0] i_q, i_next, n_w;
	logic [2:0]     vcnt_q;
	logic [1:0]     a_q, b_q;
	logic           have_q, m_tvalid_q;

	assign i_next = i_q + EIW'(1);
	assign n_w = (32'(elem_count_q) > 32'(MAX_ELEMS)) ? EIW'(MAX_ELEMS) : EIW'(elem_count_q);

	// memories
	logic [47:0]    vmem [MAX_VERTS];
	logic [31:0]    emem [MAX_ELEMS];
	logic [47:0]    vrdata;
	logic [31:0]    erdata;
	logic           vwe, ewe, vre, ere;
	logic [VAW-1:0] vwaddr, vraddr;
	logic [EAW-1:0] ewaddr, eraddr;
	logic [31:0]    slot32, i32, cidx32;
	logic [7:0]     cidx;

	assign slot32 = 32'(slot);
	assign i32    = 32'(i_q);
	assign vwe    = in_acc && (req == tpl_pkg::REQ_VERT) && (slot32 < 32'(MAX_VERTS));
	assign ewe    = in_acc && (req == tpl_pkg::REQ_TET) && (slot32 < 32'(MAX_ELEMS));
	assign vwaddr = slot32[VAW-1:0];
	assign ewaddr = slot32[EAW-1:0];
	assign eraddr = i32[EAW-1:0];
	assign ere    = (state_q == ST_ERD);
	assign vre    = (state_q == ST_VRD) && (vcnt_q < 3'd4);

	// reference corner first, then a, b, c
	always_comb begin
		case (vcnt_q)
			3'd0:    cidx = erdata[31:24];
			3'd1:    cidx = erdata[7:0];
			3'd2:    cidx = erdata[15:8];
			default: cidx = erdata[23:16];
		endcase
	end
	assign cidx32 = 32'(cidx);
	assign vraddr = cidx32[VAW-1:0];

	always_ff @(posedge clk) begin
		if (vwe)
			vmem[vwaddr] <= s_tdata[57:10];
		if (vre)
			vrdata <= vmem[vraddr];
	end

	always_ff @(posedge clk) begin
		if (ewe)
			emem[ewaddr] <= s_tdata[89:58];
		if (ere)
			erdata <= emem[eraddr];
	end

	// datapath
	logic                 vzero_q;
	logic signed [15:0]   p_q  [3];
	logic signed [15:0]   vd_q [3];
	logic signed [15:0]   vv   [3];
	logic signed [DW-1:0] qv_q [3];
	logic signed [DW-1:0] e_q  [3][3];
	logic signed [CRW-1:0] cr_q [3][3];
	logic signed [AW-1:0] acc_q, acc_n, dprod;
	logic signed [AW-1:0] dot_q [4];
	logic signed [WW-1:0] w_q [4];
	logic signed [WW-1:0] wr  [3];
	logic [EW-1:0]        err_q, best_err_q;
	logic [EIW-1:0]       best_i_q;
	logic [31:0]          best_t_q;

	logic [1:0]            pu, pv, da_i;
	logic signed [DW-1:0]  m1a, m1b, m2a, m2b, dopa;
	logic signed [33:0]    pr1, pr2;
	logic signed [CRW-1:0] crn, dopb;
	logic signed [25:0]    wsum;
	logic signed [WW-1:0]  wdn, ws;
	logic signed [24:0]    dsx;
	logic [23:0]           dist_mag;
	logic [47:0]           sq;

	logic [AW-1:0]         num_mag [3];
	logic [AW-1:0]         den_mag;
	logic [tpl_pkg::QW:0]  qmag [3];
	logic [2:0]            div_done;
	logic                  div_start, det_zero;

	function automatic logic [AW-1:0] absv(input logic signed [AW-1:0] v);
		absv = v[AW-1] ? AW'(-v) : AW'(v);
	endfunction

	function automatic logic signed [WW-1:0] sat_ratio(input logic neg,
		input logic [tpl_pkg::QW:0] m);
		logic [tpl_pkg::QW:0] t;
		t = (~m) + 1'b1;
		if (neg)
			sat_ratio = (m > tpl_pkg::MAG_NEG) ? tpl_pkg::W_MIN : t[WW-1:0];
		else
			sat_ratio = (m > tpl_pkg::MAG_POS) ? tpl_pkg::W_MAX : m[WW-1:0];
	endfunction

	always_comb begin
		for (int k = 0; k < 3; k++)
			vv[k] = vzero_q ? 16'sd0 : $signed(vrdata[16*k +: 16]);
	end

	// cross product u x v, component b_q, of edge pair a_q
	always_comb begin
		pu  = tpl_pkg::nx1(a_q);
		pv  = tpl_pkg::nx2(a_q);
		m1a = e_q[pu][tpl_pkg::nx1(b_q)];
		m1b = e_q[pv][tpl_pkg::nx2(b_q)];
		m2a = e_q[pu][tpl_pkg::nx2(b_q)];
		m2b = e_q[pv][tpl_pkg::nx1(b_q)];
		pr1 = m1a * m1b;
		pr2 = m2a * m2b;
		crn = {pr1[33], pr1} - {pr2[33], pr2};
	end

	// dot 0 is the determinant e0.(e1 x e2); dots 1..3 are q against each cross
	always_comb begin
		da_i  = (a_q == 2'd0) ? 2'd0 : a_q - 2'd1;
		dopa  = (a_q == 2'd0) ? e_q[0][b_q] : qv_q[b_q];
		dopb  = cr_q[da_i][b_q];
		dprod = dopa * dopb;
		acc_n = ((b_q == 2'd0) ? AW'(0) : acc_q) + dprod;
	end

	assign den_mag  = absv(dot_q[0]);
	assign det_zero = (dot_q[0] == '0);
	assign div_start = (state_q == ST_DSTART) && !det_zero;

	for (genvar g = 0; g < 3; g++) begin : g_div
		assign num_mag[g] = absv(dot_q[g+1]);
		assign wr[g] = sat_ratio(dot_q[g+1][AW-1] ^ dot_q[0][AW-1], qmag[g]);
		tpl_div u_div (
			.clk     (clk),
			.arst_n  (arst_n),
			.start   (div_start),
			.num_mag (num_mag[g]),
			.den_mag (den_mag),
			.done    (div_done[g]),
			.mag     (qmag[g])
		);
	end

	always_comb begin
		wsum = 26'sd65536 - {{2{w_q[0][WW-1]}}, w_q[0]} - {{2{w_q[1][WW-1]}}, w_q[1]}
			- {{2{w_q[2][WW-1]}}, w_q[2]};
		if (wsum > 26'sd8388607)
			wdn = tpl_pkg::W_MAX;
		else if (wsum < -26'sd8388608)
			wdn = tpl_pkg::W_MIN;
		else
			wdn = wsum[WW-1:0];
	end

	// distance of a weight from [0, 1]
	always_comb begin
		ws  = w_q[a_q];
		dsx = '0;
		if (ws[WW-1])
			dsx = -{ws[WW-1], ws};
		else if (ws > 24'sd65536)
			dsx = {ws[WW-1], ws} - 25'sd65536;
		dist_mag = dsx[23:0];
		sq       = dist_mag * dist_mag;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc && req == tpl_pkg::REQ_LOC) begin
					for (int k = 0; k < 3; k++)
						p_q[k] <= $signed(in_c[k]);
					best_i_q   <= '0;
					best_t_q   <= '0;
					best_err_q <= '0;
					for (int k = 0; k < 4; k++)
						w_q[k] <= '0;
				end
			end
			ST_VRD: begin
				vzero_q <= cidx32 >= 32'(MAX_VERTS);
				if (vcnt_q == 3'd1) begin
					for (int k = 0; k < 3; k++) begin
						vd_q[k] <= vv[k];
						qv_q[k] <= {p_q[k][15], p_q[k]} - {vv[k][15], vv[k]};
					end
				end else if (vcnt_q != 3'd0) begin
					for (int k = 0; k < 3; k++)
						e_q[vcnt_q[1:0] - 2'd2][k] <= {vv[k][15], vv[k]} - {vd_q[k][15], vd_q[k]};
				end
			end
			ST_CROSS: cr_q[a_q][b_q] <= crn;
			ST_DOT: begin
				acc_q <= acc_n;
				if (b_q == 2'd2)
					dot_q[a_q] <= acc_n;
			end
			ST_WGT: begin
				for (int k = 0; k < 3; k++)
					w_q[k] <= wr[k];
			end
			ST_WD: w_q[3] <= wdn;
			ST_ERR: err_q <= ((a_q == 2'd0) ? EW'(0) : err_q) + EW'(sq);
			ST_UPD: begin
				if (!have_q || err_q < best_err_q) begin
					best_err_q <= err_q;
					best_i_q   <= i_q;
					best_t_q   <= erdata;
				end
			end
			default: ;
		endcase
	end

	// best weights live apart from the working ones
	logic signed [WW-1:0] best_w_q [4];
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_acc && req == tpl_pkg::REQ_LOC) begin
			for (int k = 0; k < 4; k++)
				best_w_q[k] <= '0;
		end else if (state_q == ST_UPD && (!have_q || err_q < best_err_q)) begin
			for (int k = 0; k < 4; k++)
				best_w_q[k] <= w_q[k];
		end
	end

	// output register
	logic [143:0] m_data_q;
	logic         m_found_q;
	logic [31:0]  best_i32;
	assign best_i32 = 32'(best_i_q);

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!m_tvalid_q || m_tready)) begin
			m_found_q <= have_q;
			m_data_q  <= {6'd0, best_w_q[3], best_w_q[2], best_w_q[1], best_w_q[0],
				best_t_q[31:24], best_t_q[23:16], best_t_q[15:8], best_t_q[7:0],
				best_i32[9:0]};
		end
	end

	// load on a finished scan, drop once the receiver takes the word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (state_q == ST_DONE && (!m_tvalid_q || m_tready))
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_data_q;
	assign m_tuser[0] = m_found_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			elem_count_q <= '0;
			i_q          <= '0;
			vcnt_q       <= '0;
			a_q          <= '0;
			b_q          <= '0;
			have_q       <= 1'b0;
		end else begin
			if (cfg_we)
				elem_count_q <= cfg_wdata;
			case (state_q)
				ST_IDLE: begin
					if (in_acc && req == tpl_pkg::REQ_LOC) begin
						i_q     <= '0;
						have_q  <= 1'b0;
						state_q <= (n_w == '0) ? ST_DONE : ST_ERD;
					end
				end
				ST_ERD: begin
					vcnt_q  <= '0;
					state_q <= ST_VRD;
				end
				ST_VRD: begin
					vcnt_q <= vcnt_q + 3'd1;
					if (vcnt_q == 3'd4) begin
						a_q     <= '0;
						b_q     <= '0;
						state_q <= ST_CROSS;
					end
				end
				ST_CROSS: begin
					if (b_q == 2'd2) begin
						b_q <= '0;
						if (a_q == 2'd2) begin
							a_q     <= '0;
							state_q <= ST_DOT;
						end else begin
							a_q <= a_q + 2'd1;
						end
					end else begin
						b_q <= b_q + 2'd1;
					end
				end
				ST_DOT: begin
					if (b_q == 2'd2) begin
						b_q <= '0;
						if (a_q == 2'd3) begin
							a_q     <= '0;
							state_q <= ST_DSTART;
						end else begin
							a_q <= a_q + 2'd1;
						end
					end else begin
						b_q <= b_q + 2'd1;
					end
				end
				ST_DSTART: begin
					// drop a degenerate element
					if (det_zero) begin
						if (i_next == n_w)
							state_q <= ST_DONE;
						else begin
							i_q     <= i_next;
							state_q <= ST_ERD;
						end
					end else begin
						state_q <= ST_DWAIT;
					end
				end
				ST_DWAIT: if (div_done[0]) state_q <= ST_WGT;
				ST_WGT: state_q <= ST_WD;
				ST_WD: begin
					a_q     <= '0;
					state_q <= ST_ERR;
				end
				ST_ERR: begin
					a_q <= a_q + 2'd1;
					if (a_q == 2'd3)
						state_q <= ST_UPD;
				end
				ST_UPD: begin
					have_q <= 1'b1;
					if (i_next == n_w)
						state_q <= ST_DONE;
					else begin
						i_q     <= i_next;
						state_q <= ST_ERD;
					end
				end
				ST_DONE: begin
					// hold the result until the output register is free
					if (!m_tvalid_q || m_tready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// checks
	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		div_done[0] |-> (div_done[1] && div_done[2]))
		else $error("dividers out of step");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == ST_DONE))
		else $error("output word loaded outside the finish state");

	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && !m_found_q) |-> (m_data_q == '0))
		else $error("empty result carries data");

	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !s_tready)
		else $error("input taken during a scan");

endmodule

`default_nettype wire

/* src/tpl_div.sv */
// Iterative restoring divider: floor(num * 2^16 / den) as a Q8.16 magnitude.
// One quotient bit per cycle, integer bits first; depends on tpl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tpl_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [tpl_pkg::ACC_W-1:0] num_mag,
	input  logic [tpl_pkg::ACC_W-1:0] den_mag,
	output logic                      done,
	output logic [tpl_pkg::QW:0]      mag
);

	localparam int DVW = tpl_pkg::DVW;
	localparam int QW  = tpl_pkg::QW;
	localparam int IS  = tpl_pkg::INT_STEPS;
	localparam int CW  = $clog2(QW);

	logic [DVW-1:0] r_q, dv_q, r_sh, r_n, dv_n;
	logic [QW-1:0]  quo_q;
	logic [CW-1:0]  cnt_q;
	logic           ovf_q, busy_q, done_q, cmp, int_ph;

	always_comb begin
		int_ph = cnt_q < CW'(IS);
		r_sh   = int_ph ? r_q : {r_q[DVW-2:0], 1'b0};
		cmp    = r_sh >= dv_q;
		r_n    = cmp ? r_sh - dv_q : r_sh;
		// walk the divisor down to den over the integer bits, then hold it
		dv_n   = (int_ph && cnt_q != CW'(IS - 1)) ? (dv_q >> 1) : dv_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CW'(1);
			if (cnt_q == CW'(QW - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q   <= {{(DVW - tpl_pkg::ACC_W){1'b0}}, num_mag};
			dv_q  <= {{(DVW - tpl_pkg::ACC_W - IS + 1){1'b0}}, den_mag, {(IS - 1){1'b0}}};
			ovf_q <= {{IS{1'b0}}, num_mag} >= {den_mag, {IS{1'b0}}};
			quo_q <= '0;
		end else if (busy_q) begin
			r_q   <= r_n;
			dv_q  <= dv_n;
			quo_q <= {quo_q[QW-2:0], cmp};
		end
	end

	assign done = done_q;
	assign mag  = ovf_q ? tpl_pkg::MAG_SAT : {1'b0, quo_q};

endmodule

`default_nettype wire
